// File: hdl/rv32_pkg.sv
// Shared types and constants for the RV32IM execute core.
package rv32_pkg;

  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_AUIPC  = 7'h17;
  localparam logic [6:0] OP_JAL    = 7'h6f;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_REG    = 7'h33;
  localparam logic [6:0] OP_SYSTEM = 7'h73;

  localparam logic [31:0] INSN_MRET   = 32'h30200073;
  localparam logic [31:0] INSN_ECALL  = 32'h00000073;
  localparam logic [31:0] INSN_EBREAK = 32'h00100073;

  localparam logic [11:0] CSR_MSTATUS = 12'h300;
  localparam logic [11:0] CSR_MTVEC   = 12'h305;
  localparam logic [11:0] CSR_MEPC    = 12'h341;
  localparam logic [11:0] CSR_MCAUSE  = 12'h342;

  localparam logic [31:0] CAUSE_ECALL_M = 32'd11;

  localparam logic [1:0] ST_NORMAL  = 2'd0;
  localparam logic [1:0] ST_HALT    = 2'd1;
  localparam logic [1:0] ST_ILLEGAL = 2'd2;

  typedef struct packed {
    logic [31:0] instr_pc;
    logic [31:0] next_pc;
    logic        reg_write;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    logic [1:0]  status;
    logic [31:0] halt_code;
  } result_t;

endpackage

// File: hdl/rv32_divider.sv
// Radix-2 restoring divider for div, divu, rem and remu.
module rv32_divider import rv32_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient,
  output logic [31:0] remainder
);

  logic        busy_r, busy_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] dvs_r, dvs_nxt;
  logic        done_r, done_nxt;
  logic [32:0] trial;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    done_nxt = 1'b0;
    trial    = {rem_r[31:0], quo_r[31]} - {1'b0, dvs_r};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 6'd0;
      quo_nxt  = dividend;
      rem_nxt  = 33'd0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      // One quotient bit per cycle; the dividend shifts out of quo_r as bits enter.
      if (trial[32]) begin
        rem_nxt = {rem_r[31:0], quo_r[31]};
        quo_nxt = {quo_r[30:0], 1'b0};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[30:0], 1'b1};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r[31:0];

endmodule

// File: hdl/rv32im_execute_core_unit.sv
// Top level of the RV32IM execute core: register file, CSRs, data memory and sequencer.
//
//   channel | direction | handshake           | payload
//   in_     | input     | in_valid/in_ready   | in_instruction
//   out_    | output    | out_valid/out_ready | out_instr_pc .. out_halt_code
//   cfg_    | input     | cfg_wr_en           | cfg_wr_data (pc)
//
// A request passes through accept and register read, operand capture, execute and
// writeback. A load or a store adds a state for the data memory read, and a multiply
// adds one for the registered product. Division waits in its own state until the
// radix-2 divider signals done.
// Reset is synchronous; after reset the register file is cleared by a sweep of all 32
// registers, during which no request is taken. A finished result waits in the output
// register while the next request is already accepted and processed.
module rv32im_execute_core_unit import rv32_pkg::*; #(
  parameter int DMEM_WORDS = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_instruction,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_instr_pc,
  output logic [31:0] out_next_pc,
  output logic        out_reg_write,
  output logic [4:0]  out_reg_index,
  output logic [31:0] out_reg_value,
  output logic [1:0]  out_status,
  output logic [31:0] out_halt_code
);

  localparam int AW = (DMEM_WORDS > 1) ? $clog2(DMEM_WORDS) : 1;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_EXEC  = 3'd3;
  localparam logic [2:0] S_MEM   = 3'd4;
  localparam logic [2:0] S_MUL   = 3'd5;
  localparam logic [2:0] S_DIV   = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]  state_r, state_nxt;
  logic [4:0]  clr_cnt_r;
  logic [31:0] pc_r;
  logic [31:0] ins_r;
  logic [31:0] a_r, b_r, a0_r;
  logic [31:0] csr_r [4];
  logic [31:0] rf_a [32];
  logic [31:0] rf_b [32];
  logic [31:0] dmem [DMEM_WORDS];
  logic [31:0] ra_q, rb_q, r10_q, dm_q;
  logic        outv_r;
  result_t     out_r;
  logic [63:0] prod_r;
  logic [31:0] ld_r;

  // Decode fields.
  logic [6:0] op;
  logic [2:0] f3;
  logic [6:0] f7;
  logic [4:0] rd;
  logic [31:0] immi, imms, immb, immj;
  assign op = ins_r[6:0];
  assign f3 = ins_r[14:12];
  assign f7 = ins_r[31:25];
  assign rd = ins_r[11:7];
  assign immi = {{20{ins_r[31]}}, ins_r[31:20]};
  assign imms = {{20{ins_r[31]}}, ins_r[31:25], ins_r[11:7]};
  assign immb = {{20{ins_r[31]}}, ins_r[7], ins_r[30:25], ins_r[11:8], 1'b0};
  assign immj = {{12{ins_r[31]}}, ins_r[19:12], ins_r[20], ins_r[30:21], 1'b0};

  logic [31:0] mem_ad;
  logic [AW-1:0] widx;
  assign mem_ad = a_r + ((op == OP_STORE) ? imms : immi);
  assign widx   = mem_ad[AW+1:2];

  // Register file: two read copies written together, read addresses from the request.
  logic        rf_we;
  logic [4:0]  rf_wa;
  logic [31:0] rf_wd;
  logic        in_fire;
  assign in_fire = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rf_we) begin
      rf_a[rf_wa] <= rf_wd;
      rf_b[rf_wa] <= rf_wd;
    end
    ra_q  <= rf_a[in_instruction[19:15]];
    rb_q  <= rf_b[in_instruction[24:20]];
    r10_q <= rf_a[5'd10];
  end

  // Data memory read for loads and stores; writes happen at writeback.
  logic          dm_we;
  logic [31:0]   dm_wd;
  always_ff @(posedge clk) begin
    if (dm_we) dmem[widx] <= dm_wd;
    dm_q <= dmem[widx];
  end

  // Divider.
  logic        sgn_div, na, nb;
  logic [31:0] ua, ub, dq, dr;
  logic        div_start, div_done;
  assign sgn_div = !f3[0];
  assign na = sgn_div && a_r[31];
  assign nb = sgn_div && b_r[31];
  assign ua = na ? (32'd0 - a_r) : a_r;
  assign ub = nb ? (32'd0 - b_r) : b_r;

  rv32_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (ua),
    .divisor  (ub),
    .done     (div_done),
    .quotient (dq),
    .remainder(dr)
  );

  // Classification.
  logic is_div, is_mul, is_mem;
  assign is_mul = (op == OP_REG) && (f7 == 7'd1) && !f3[2];
  assign is_div = (op == OP_REG) && (f7 == 7'd1) && f3[2];
  assign is_mem = (op == OP_LOAD) || (op == OP_STORE);

  // Multiply: operands extended per variant, one 33x33 signed product.
  logic signed [32:0] ma, mb;
  assign ma = {(f3 == 3'd1 || f3 == 3'd2) && a_r[31], a_r};
  assign mb = {(f3 == 3'd1) && b_r[31], b_r};
  logic signed [65:0] mfull;
  assign mfull = ma * mb;

  // Execute and result.
  logic        bad, halt, wr, t;
  logic [31:0] val, npc, hcode, lw;
  logic [31:0] csr_old, csr_new;
  logic [1:0]  csr_slot;
  logic        csr_hit, csr_we;
  logic [4:0]  sh;
  logic [31:0] st_mask, st_data;

  always_comb begin
    unique case (ins_r[31:20])
      CSR_MSTATUS: begin csr_slot = 2'd0; csr_hit = 1'b1; end
      CSR_MTVEC:   begin csr_slot = 2'd1; csr_hit = 1'b1; end
      CSR_MEPC:    begin csr_slot = 2'd2; csr_hit = 1'b1; end
      CSR_MCAUSE:  begin csr_slot = 2'd3; csr_hit = 1'b1; end
      default:     begin csr_slot = 2'd0; csr_hit = 1'b0; end
    endcase
    csr_old = csr_hit ? csr_r[csr_slot] : 32'd0;
    csr_new = (f3 == 3'd1) ? a_r : (csr_old | a_r);
  end

  always_comb begin
    lw = ld_r >> {mem_ad[1:0], 3'b000};
    st_mask = ((f3 == 3'd0) ? 32'hff : (f3 == 3'd1) ? 32'hffff : 32'hffffffff)
              << {mem_ad[1:0], 3'b000};
    st_data = (b_r << {mem_ad[1:0], 3'b000}) & st_mask;
  end

  always_comb begin
    bad = 1'b0; halt = 1'b0; wr = 1'b0; val = 32'd0; hcode = 32'd0; t = 1'b0;
    npc = pc_r + 32'd4; csr_we = 1'b0;
    sh = (op == OP_REG) ? b_r[4:0] : ins_r[24:20];
    unique case (op)
      OP_LUI:   begin wr = 1'b1; val = {ins_r[31:12], 12'd0}; end
      OP_AUIPC: begin wr = 1'b1; val = pc_r + {ins_r[31:12], 12'd0}; end
      OP_JAL:   begin wr = 1'b1; val = pc_r + 32'd4; npc = pc_r + immj; end
      OP_JALR: begin
        if (f3 != 3'd0) bad = 1'b1;
        else begin wr = 1'b1; val = pc_r + 32'd4; npc = (a_r + immi) & ~32'd1; end
      end
      OP_BRANCH: begin
        unique case (f3)
          3'd0: t = a_r == b_r;
          3'd1: t = a_r != b_r;
          3'd4: t = $signed(a_r) < $signed(b_r);
          3'd5: t = $signed(a_r) >= $signed(b_r);
          3'd6: t = a_r < b_r;
          3'd7: t = a_r >= b_r;
          default: bad = 1'b1;
        endcase
        if (t) npc = pc_r + immb;
      end
      OP_LOAD: begin
        if (f3 == 3'd3 || f3 > 3'd5) bad = 1'b1;
        else if ((f3[1:0] == 2'd1 && mem_ad[0]) || (f3 == 3'd2 && mem_ad[1:0] != 2'd0))
          bad = 1'b1;
        else begin
          wr = 1'b1;
          unique case (f3)
            3'd0: val = {{24{lw[7]}}, lw[7:0]};
            3'd1: val = {{16{lw[15]}}, lw[15:0]};
            3'd2: val = lw;
            3'd4: val = {24'd0, lw[7:0]};
            default: val = {16'd0, lw[15:0]};
          endcase
        end
      end
      OP_STORE: begin
        if (f3 > 3'd2 || (f3 == 3'd1 && mem_ad[0]) || (f3 == 3'd2 && mem_ad[1:0] != 2'd0))
          bad = 1'b1;
      end
      OP_IMM: begin
        wr = 1'b1;
        unique case (f3)
          3'd0: val = a_r + immi;
          3'd2: val = {31'd0, $signed(a_r) < $signed(immi)};
          3'd3: val = {31'd0, a_r < immi};
          3'd4: val = a_r ^ immi;
          3'd6: val = a_r | immi;
          3'd7: val = a_r & immi;
          3'd1: if (f7 == 7'd0) val = a_r << sh; else bad = 1'b1;
          default: begin
            if (f7 == 7'd0) val = a_r >> sh;
            else if (f7 == 7'h20) val = 32'($signed(a_r) >>> sh);
            else bad = 1'b1;
          end
        endcase
      end
      OP_REG: begin
        wr = 1'b1;
        if (f7 == 7'd0) begin
          unique case (f3)
            3'd0: val = a_r + b_r;
            3'd1: val = a_r << sh;
            3'd2: val = {31'd0, $signed(a_r) < $signed(b_r)};
            3'd3: val = {31'd0, a_r < b_r};
            3'd4: val = a_r ^ b_r;
            3'd5: val = a_r >> sh;
            3'd6: val = a_r | b_r;
            default: val = a_r & b_r;
          endcase
        end else if (f7 == 7'h20 && f3 == 3'd0) val = a_r - b_r;
        else if (f7 == 7'h20 && f3 == 3'd5) val = 32'($signed(a_r) >>> sh);
        else if (f7 == 7'd1) begin
          unique case (f3)
            3'd0: val = prod_r[31:0];
            3'd1, 3'd2, 3'd3: val = prod_r[63:32];
            3'd4: begin
              if (b_r == 32'd0) val = 32'hffffffff;
              else if (b_r == 32'hffffffff) val = 32'd0 - a_r;
              else val = (na != nb) ? (32'd0 - dq) : dq;
            end
            3'd5: val = (b_r == 32'd0) ? 32'hffffffff : dq;
            3'd6: begin
              if (b_r == 32'd0) val = a_r;
              else if (b_r == 32'hffffffff) val = 32'd0;
              else val = na ? (32'd0 - dr) : dr;
            end
            default: val = (b_r == 32'd0) ? a_r : dr;
          endcase
        end else bad = 1'b1;
      end
      OP_SYSTEM: begin
        if (f3 == 3'd1 || f3 == 3'd2) begin
          wr = 1'b1; val = csr_old; csr_we = csr_hit;
        end else if (ins_r == INSN_MRET) npc = csr_r[2];
        else if (ins_r == INSN_ECALL) npc = csr_r[1];
        else if (ins_r == INSN_EBREAK) begin
          halt = 1'b1; hcode = a0_r; npc = pc_r;
        end else bad = 1'b1;
      end
      default: bad = 1'b1;
    endcase
    if (bad) begin wr = 1'b0; npc = pc_r; csr_we = 1'b0; end
    if (rd == 5'd0) wr = 1'b0;
    if (!wr) val = 32'd0;
  end

  // Sequencer.
  logic out_free;
  assign out_free = !outv_r || out_ready;
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    unique case (state_r)
      S_CLEAR: if (clr_cnt_r == 5'd31) state_nxt = S_IDLE;
      S_IDLE:  if (in_fire) state_nxt = S_READ;
      S_READ:  state_nxt = S_EXEC;
      S_EXEC: begin
        if (is_div) begin div_start = 1'b1; state_nxt = S_DIV; end
        else if (is_mul) state_nxt = S_MUL;
        else if (is_mem) state_nxt = S_MEM;
        else state_nxt = S_DONE;
      end
      S_MEM:  state_nxt = S_DONE;
      S_MUL:  state_nxt = S_DONE;
      S_DIV:  if (div_done) state_nxt = S_DONE;
      default: if (out_free) state_nxt = S_IDLE;
    endcase
  end

  logic commit;
  assign commit = (state_r == S_DONE) && out_free;

  always_comb begin
    rf_we = 1'b0; rf_wa = rd; rf_wd = val;
    if (state_r == S_CLEAR) begin
      rf_we = 1'b1; rf_wa = clr_cnt_r; rf_wd = 32'd0;
    end else if (commit && wr) rf_we = 1'b1;
    dm_we = commit && (op == OP_STORE) && !bad;
    dm_wd = (ld_r & ~st_mask) | st_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_cnt_r <= 5'd0;
      pc_r      <= 32'h80000000;
      outv_r    <= 1'b0;
      for (int i = 0; i < 4; i++) csr_r[i] <= 32'd0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) clr_cnt_r <= clr_cnt_r + 5'd1;
      if (commit) begin
        outv_r <= 1'b1;
        pc_r   <= npc;
        if (csr_we) csr_r[csr_slot] <= csr_new;
        if (op == OP_SYSTEM && ins_r == INSN_ECALL) begin
          csr_r[2] <= pc_r;
          csr_r[3] <= CAUSE_ECALL_M;
        end
      end else begin
        if (out_valid && out_ready) outv_r <= 1'b0;
        if (cfg_wr_en) pc_r <= cfg_wr_data;
      end
    end
    if (in_fire) ins_r <= in_instruction;
    if (state_r == S_READ) begin
      a_r  <= (ins_r[19:15] == 5'd0) ? 32'd0 : ra_q;
      b_r  <= (ins_r[24:20] == 5'd0) ? 32'd0 : rb_q;
      a0_r <= r10_q;
    end
    if (state_r == S_EXEC) prod_r <= mfull[63:0];
    if (state_r == S_MEM) ld_r <= dm_q;
    if (commit) begin
      out_r.instr_pc  <= pc_r;
      out_r.next_pc   <= npc;
      out_r.reg_write <= wr;
      out_r.reg_index <= wr ? rd : 5'd0;
      out_r.reg_value <= val;
      out_r.status    <= bad ? ST_ILLEGAL : (halt ? ST_HALT : ST_NORMAL);
      out_r.halt_code <= hcode;
    end
  end

  assign out_valid     = outv_r;
  assign out_instr_pc  = out_r.instr_pc;
  assign out_next_pc   = out_r.next_pc;
  assign out_reg_write = out_r.reg_write;
  assign out_reg_index = out_r.reg_index;
  assign out_reg_value = out_r.reg_value;
  assign out_status    = out_r.status;
  assign out_halt_code = out_r.halt_code;

  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !in_ready) else $error("request taken during clear");
  a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> out_valid) else $error("commit without result");
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV)) else $error("divider done outside wait");
  a_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_reg_write) |-> (out_reg_index == 5'd0))
    else $error("index without write");

endmodule
